### src/igcf_pkg.sv
package igcf_pkg;

  localparam int VECTOR_WIDTH_DEFAULT = 24;

  // Configuration port
  localparam int CFG_DATA_W  = 20;
  localparam int CFG_INDEX_W = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_BIAS_X      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BIAS_Y      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BIAS_Z      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_LOOP_PERIOD = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_GROUND_KEEP = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_AIR_KEEP    = 3'd5;

  localparam logic [19:0] PERIOD_RESET      = 20'd4194;
  localparam logic [15:0] GROUND_KEEP_RESET = 16'd63500;
  localparam logic [15:0] AIR_KEEP_RESET    = 16'd65433;

  // Accel gate: 0.7 G < |a| < 1.3 G at 2048 counts per G, on |a|^2
  localparam logic [35:0] GATE_LO = 36'd2055208;
  localparam logic [35:0] GATE_HI = 36'd7088374;

  // Iteration step counter
  localparam int STEP_W = 5;

  // CORDIC atan2 constants, Q.20 radians
  localparam int CORDIC_STEPS = 20;
  localparam logic signed [23:0] CORDIC_HALF_PI = 24'sd1647099;
  localparam logic signed [23:0] ATAN_Q20 [CORDIC_STEPS] = '{
    24'sd823550, 24'sd486170, 24'sd256879, 24'sd130396, 24'sd65451,
    24'sd32757,  24'sd16383,  24'sd8192,   24'sd4096,   24'sd2048,
    24'sd1024,   24'sd512,    24'sd256,    24'sd128,    24'sd64,
    24'sd32,     24'sd16,     24'sd8,      24'sd4,      24'sd2
  };

  typedef enum logic [4:0] {
    DP_NOP,
    DP_LOAD,
    DP_DELTA,
    DP_ROT_MUL,
    DP_ROT_ADD,
    DP_ASQ,
    DP_SQRT_A,
    DP_SQRT_G,
    DP_SQRT_STEP,
    DP_DIV_A,
    DP_DIV_G,
    DP_DIV_STEP,
    DP_DIV_END_A,
    DP_DIV_END_G,
    DP_BL_MUL1,
    DP_BL_MUL2,
    DP_BL_WR,
    DP_GSQ,
    DP_COR_INIT,
    DP_COR_STEP,
    DP_COR_END,
    DP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t            op;
    logic [1:0]        axis;
    logic [STEP_W-1:0] step;
  } dp_cmd_t;

  typedef struct packed {
    logic gate_pass;
    logic gm_zero;
    logic ground;
    logic horizon;
  } dp_status_t;

endpackage

### src/igcf_if.sv
interface igcf_in_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] rate_x;
  logic signed [23:0] rate_y;
  logic signed [23:0] rate_z;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic               on_ground;
  logic               horizon_enable;

  modport source (
    output valid, rate_x, rate_y, rate_z, accel_x, accel_y, accel_z,
           on_ground, horizon_enable,
    input  ready
  );
  modport sink (
    input  valid, rate_x, rate_y, rate_z, accel_x, accel_y, accel_z,
           on_ground, horizon_enable,
    output ready
  );
endinterface

interface igcf_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] grav_x;
  logic signed [23:0] grav_y;
  logic signed [23:0] grav_z;
  logic signed [15:0] roll_angle;
  logic signed [15:0] pitch_angle;
  logic               accel_accepted;

  modport source (
    output valid, grav_x, grav_y, grav_z, roll_angle, pitch_angle, accel_accepted,
    input  ready
  );
  modport sink (
    input  valid, grav_x, grav_y, grav_z, roll_angle, pitch_angle, accel_accepted,
    output ready
  );
endinterface

### src/igcf_ctrl.sv
module igcf_ctrl #(
  parameter int VECTOR_WIDTH = igcf_pkg::VECTOR_WIDTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  igcf_pkg::dp_status_t status,
  output igcf_pkg::dp_cmd_t    cmd
);
  import igcf_pkg::*;

  localparam int SQW      = (2 * VECTOR_WIDTH > 44) ? 2 * VECTOR_WIDTH : 44;
  localparam int SQ_STEPS = SQW / 2;

  localparam logic [STEP_W-1:0] SQ_LAST  = STEP_W'(SQ_STEPS - 1);
  localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(VECTOR_WIDTH - 1);
  localparam logic [STEP_W-1:0] COR_LAST = STEP_W'(CORDIC_STEPS - 1);
  localparam logic [STEP_W-1:0] ROT_LAST = STEP_W'(5);

  typedef enum logic [4:0] {
    S_IDLE, S_DELTA, S_ROT_MUL, S_ROT_ADD, S_ASQ, S_GATE,
    S_SQRT_A, S_SQA, S_NDIV_INIT, S_NDIV, S_NDIV_END,
    S_BL1, S_BL2, S_BLW, S_GSQ, S_SQRT_G, S_SQG, S_GCHK,
    S_GDIV_INIT, S_GDIV, S_GDIV_END, S_ANG, S_COR_INIT, S_COR,
    S_COR_END, S_FINISH
  } state_t;

  state_t            state;
  logic [STEP_W-1:0] cnt;
  logic [1:0]        axis;
  logic              out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // Sequence the item through the datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      axis      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_DELTA;
            axis  <= '0;
          end
        end
        S_DELTA: begin
          if (axis == 2'd2) begin
            state <= S_ROT_MUL;
            cnt   <= '0;
            axis  <= '0;
          end else axis <= axis + 2'd1;
        end
        S_ROT_MUL: state <= S_ROT_ADD;
        S_ROT_ADD: begin
          if (cnt == ROT_LAST) begin
            state <= S_ASQ;
            axis  <= '0;
          end else begin
            cnt   <= cnt + 1'b1;
            state <= S_ROT_MUL;
          end
        end
        S_ASQ: begin
          if (axis == 2'd2) state <= S_GATE;
          else axis <= axis + 2'd1;
        end
        S_GATE: state <= status.gate_pass ? S_SQRT_A : S_ANG;
        S_SQRT_A: begin
          state <= S_SQA;
          cnt   <= '0;
        end
        S_SQA: begin
          if (cnt == SQ_LAST) begin
            state <= S_NDIV_INIT;
            axis  <= '0;
          end else cnt <= cnt + 1'b1;
        end
        S_NDIV_INIT: begin
          state <= S_NDIV;
          cnt   <= '0;
        end
        S_NDIV: begin
          if (cnt == DIV_LAST) state <= S_NDIV_END;
          else cnt <= cnt + 1'b1;
        end
        S_NDIV_END: state <= S_BL1;
        S_BL1:      state <= S_BL2;
        S_BL2:      state <= S_BLW;
        S_BLW: begin
          if (axis == 2'd2) begin
            axis  <= '0;
            state <= status.ground ? S_ANG : S_GSQ;
          end else begin
            axis  <= axis + 2'd1;
            state <= S_NDIV_INIT;
          end
        end
        S_GSQ: begin
          if (axis == 2'd2) state <= S_SQRT_G;
          else axis <= axis + 2'd1;
        end
        S_SQRT_G: begin
          state <= S_SQG;
          cnt   <= '0;
        end
        S_SQG: begin
          if (cnt == SQ_LAST) state <= S_GCHK;
          else cnt <= cnt + 1'b1;
        end
        S_GCHK: begin
          axis  <= '0;
          state <= status.gm_zero ? S_ANG : S_GDIV_INIT;
        end
        S_GDIV_INIT: begin
          state <= S_GDIV;
          cnt   <= '0;
        end
        S_GDIV: begin
          if (cnt == DIV_LAST) state <= S_GDIV_END;
          else cnt <= cnt + 1'b1;
        end
        S_GDIV_END: begin
          if (axis == 2'd2) state <= S_ANG;
          else begin
            axis  <= axis + 2'd1;
            state <= S_GDIV_INIT;
          end
        end
        S_ANG: begin
          axis  <= '0;
          state <= status.horizon ? S_COR_INIT : S_FINISH;
        end
        S_COR_INIT: begin
          state <= S_COR;
          cnt   <= '0;
        end
        S_COR: begin
          if (cnt == COR_LAST) state <= S_COR_END;
          else cnt <= cnt + 1'b1;
        end
        S_COR_END: begin
          if (axis == 2'd1) state <= S_FINISH;
          else begin
            axis  <= 2'd1;
            state <= S_COR_INIT;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Decode the datapath command for this state
  always_comb begin
    cmd.axis = axis;
    cmd.step = cnt;
    case (state)
      S_IDLE:      cmd.op = in_valid ? DP_LOAD : DP_NOP;
      S_DELTA:     cmd.op = DP_DELTA;
      S_ROT_MUL:   cmd.op = DP_ROT_MUL;
      S_ROT_ADD:   cmd.op = DP_ROT_ADD;
      S_ASQ:       cmd.op = DP_ASQ;
      S_SQRT_A:    cmd.op = DP_SQRT_A;
      S_SQA:       cmd.op = DP_SQRT_STEP;
      S_NDIV_INIT: cmd.op = DP_DIV_A;
      S_NDIV:      cmd.op = DP_DIV_STEP;
      S_NDIV_END:  cmd.op = DP_DIV_END_A;
      S_BL1:       cmd.op = DP_BL_MUL1;
      S_BL2:       cmd.op = DP_BL_MUL2;
      S_BLW:       cmd.op = DP_BL_WR;
      S_GSQ:       cmd.op = DP_GSQ;
      S_SQRT_G:    cmd.op = DP_SQRT_G;
      S_SQG:       cmd.op = DP_SQRT_STEP;
      S_GDIV_INIT: cmd.op = DP_DIV_G;
      S_GDIV:      cmd.op = DP_DIV_STEP;
      S_GDIV_END:  cmd.op = DP_DIV_END_G;
      S_COR_INIT:  cmd.op = DP_COR_INIT;
      S_COR:       cmd.op = DP_COR_STEP;
      S_COR_END:   cmd.op = DP_COR_END;
      S_FINISH:    cmd.op = out_free ? DP_OUT : DP_NOP;
      default:     cmd.op = DP_NOP;
    endcase
  end

endmodule

### src/igcf_datapath.sv
module igcf_datapath #(
  parameter int VECTOR_WIDTH = igcf_pkg::VECTOR_WIDTH_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [igcf_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [igcf_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  igcf_pkg::dp_cmd_t                    cmd,
  output igcf_pkg::dp_status_t                 status,
  input  logic signed [23:0]                   rate_x,
  input  logic signed [23:0]                   rate_y,
  input  logic signed [23:0]                   rate_z,
  input  logic signed [15:0]                   accel_x,
  input  logic signed [15:0]                   accel_y,
  input  logic signed [15:0]                   accel_z,
  input  logic                                 on_ground,
  input  logic                                 horizon_enable,
  output logic signed [23:0]                   grav_x,
  output logic signed [23:0]                   grav_y,
  output logic signed [23:0]                   grav_z,
  output logic signed [15:0]                   roll_angle,
  output logic signed [15:0]                   pitch_angle,
  output logic                                 accel_accepted
);
  import igcf_pkg::*;

  localparam int VW  = VECTOR_WIDTH;
  localparam int GF  = VW - 4;
  localparam int SQW = (2 * VW > 44) ? 2 * VW : 44;
  localparam int DW  = (VW > 22) ? VW : 22;
  localparam int DVW = DW + VW + 1;
  localparam int CW  = VW + 3;
  localparam int SHR = (GF >= 20) ? GF - 20 : 0;
  localparam int SHL = (GF < 20) ? 20 - GF : 0;

  localparam logic signed [VW+19:0] VMAX = {{21{1'b0}}, {(VW-1){1'b1}}};
  localparam logic signed [VW+19:0] VMIN = {{21{1'b1}}, {(VW-1){1'b0}}};
  localparam logic signed [44:0]    DLIM = 45'sd2147483648;

  // Saturate to the vector range
  function automatic logic signed [VW-1:0] sat_v(input logic signed [VW+19:0] v);
    if (v > VMAX) return VMAX[VW-1:0];
    if (v < VMIN) return VMIN[VW-1:0];
    return v[VW-1:0];
  endfunction

  // Rescale a vector component to Q.20 and saturate to 24 bits
  function automatic logic signed [23:0] to_q20(input logic signed [VW-1:0] v);
    logic signed [VW+7:0] ext;
    logic signed [VW+7:0] sh;
    ext = (VW+8)'(v);
    sh  = (ext <<< SHL) >>> SHR;
    if (sh > $signed((VW+8)'(8388607))) return 24'sh7FFFFF;
    if (sh < $signed((VW+8)'(-8388608))) return 24'sh800000;
    return sh[23:0];
  endfunction

  // Small-angle rotation order: z-=dx*x, x+=dx*z, y+=dy*z, z-=dy*y, x-=dz*y, y+=dz*x
  function automatic logic [1:0] rot_dst(input logic [2:0] s);
    case (s)
      3'd0, 3'd3: return 2'd2;
      3'd1, 3'd4: return 2'd0;
      default:    return 2'd1;
    endcase
  endfunction

  function automatic logic [1:0] rot_src(input logic [2:0] s);
    case (s)
      3'd0, 3'd5: return 2'd0;
      3'd1, 3'd2: return 2'd2;
      default:    return 2'd1;
    endcase
  endfunction

  function automatic logic [1:0] rot_dax(input logic [2:0] s);
    case (s)
      3'd0, 3'd1: return 2'd0;
      3'd2, 3'd3: return 2'd1;
      default:    return 2'd2;
    endcase
  endfunction

  function automatic logic rot_neg(input logic [2:0] s);
    case (s)
      3'd0, 3'd3, 3'd4: return 1'b1;
      default:          return 1'b0;
    endcase
  endfunction

  // Configuration and captured input
  logic signed [15:0] bias [3];
  logic [19:0]        period;
  logic [15:0]        keep_ground;
  logic [15:0]        keep_air;
  logic signed [23:0] rate [3];
  logic signed [15:0] accel [3];
  logic               ground;
  logic               horizon;

  // Filter state and working registers
  logic signed [VW-1:0]  g [3];
  logic signed [15:0]    ang [2];
  logic signed [32:0]    d [3];
  logic signed [VW+32:0] rprod;
  logic [35:0]           a2;
  logic [2*VW-1:0]       gacc;
  logic [SQW-1:0]        sx;
  logic [SQW-1:0]        sr;
  logic [DVW-1:0]        rem;
  logic [DW-1:0]         den;
  logic [VW-1:0]         quo;
  logic                  dneg;
  logic signed [VW:0]    n;
  logic signed [VW+18:0] bacc;
  logic signed [CW-1:0]  cx;
  logic signed [CW-1:0]  cy;
  logic signed [23:0]    cang;
  logic                  czero;
  logic                  accepted;

  // Result word
  logic signed [23:0] res_grav [3];
  logic signed [15:0] res_roll;
  logic signed [15:0] res_pitch;
  logic               res_acc;

  // Combinational terms
  logic [1:0]            ax;
  logic [2:0]            rs;
  logic signed [VW-1:0]  gax;
  logic signed [44:0]    dprod;
  logic signed [44:0]    dq;
  logic signed [32:0]    dclamp;
  logic signed [VW+32:0] rmul;
  logic signed [VW+2:0]  rterm;
  logic signed [VW+3:0]  rdst;
  logic signed [VW+3:0]  rsum;
  logic signed [16:0]    aval;
  logic [16:0]           amag;
  logic signed [33:0]    asq;
  logic signed [2*VW-1:0] gsq;
  logic signed [VW:0]    gext;
  logic [VW-1:0]         gmag;
  logic [SQW-1:0]        sbit;
  logic [SQW-1:0]        strial;
  logic [DVW-1:0]        dsh;
  logic signed [VW:0]    qs;
  logic [15:0]           wsel;
  logic [16:0]           wc;
  logic signed [VW+18:0] bm1;
  logic signed [VW+18:0] bm2;
  logic signed [VW+18:0] bsh;
  logic signed [CW-1:0]  cnum;
  logic signed [CW-1:0]  cden;
  logic signed [CW-1:0]  cxs;
  logic signed [CW-1:0]  cys;
  logic signed [23:0]    cround;
  logic signed [15:0]    csat;

  always_comb begin
    ax   = cmd.axis;
    rs   = cmd.step[2:0];
    gax  = g[ax];

    // delta angle, clamped to +-2 rad
    dprod = rate[ax] * $signed({1'b0, period});
    dq    = dprod >>> 10;
    if (dq > DLIM) dclamp = DLIM[32:0];
    else if (dq < -DLIM) dclamp = 33'sh180000000;
    else dclamp = dq[32:0];

    // rotation term
    rmul  = d[rot_dax(rs)] * g[rot_src(rs)];
    rterm = $signed(rprod[VW+32:30]);
    rdst  = (VW+4)'(g[rot_dst(rs)]);
    rsum  = rot_neg(rs) ? rdst - (VW+4)'(rterm) : rdst + (VW+4)'(rterm);

    // bias-corrected accel
    aval = 17'(accel[ax]) - 17'(bias[ax]);
    amag = aval[16] ? 17'(-aval) : 17'(aval);
    asq  = aval * aval;

    gsq  = gax * gax;
    gext = (VW+1)'(gax);
    gmag = gax[VW-1] ? VW'(-gext) : VW'(gext);

    // square root digit
    sbit   = {{(SQW-1){1'b0}}, 1'b1} << (SQW - 2 - 2 * int'(cmd.step));
    strial = sr + sbit;

    // quotient bit
    dsh = DVW'(den) << (VW - 1 - int'(cmd.step));
    qs  = dneg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

    // blend weights
    wsel = ground ? keep_ground : keep_air;
    wc   = 17'h10000 - {1'b0, wsel};
    bm1  = $signed({1'b0, wsel}) * gax;
    bm2  = $signed({1'b0, wc}) * n;
    bsh  = bacc >>> 16;

    // CORDIC
    cnum = CW'(ax[0] ? g[1] : g[0]);
    cden = CW'(g[2]);
    cxs  = cx >>> cmd.step;
    cys  = cy >>> cmd.step;
    cround = (cang + 24'sd128) >>> 8;
    if (cround > 24'sd32767) csat = 16'sh7FFF;
    else if (cround < -24'sd32768) csat = 16'sh8000;
    else csat = cround[15:0];
  end

  assign status.gate_pass = (a2 > GATE_LO) && (a2 < GATE_HI);
  assign status.gm_zero   = (sr == '0);
  assign status.ground    = ground;
  assign status.horizon   = horizon;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bias[0]     <= '0;
      bias[1]     <= '0;
      bias[2]     <= '0;
      period      <= PERIOD_RESET;
      keep_ground <= GROUND_KEEP_RESET;
      keep_air    <= AIR_KEEP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BIAS_X:      bias[0]     <= cfg_data[15:0];
        REG_BIAS_Y:      bias[1]     <= cfg_data[15:0];
        REG_BIAS_Z:      bias[2]     <= cfg_data[15:0];
        REG_LOOP_PERIOD: period      <= cfg_data;
        REG_GROUND_KEEP: keep_ground <= cfg_data[15:0];
        REG_AIR_KEEP:    keep_air    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      g[0]   <= '0;
      g[1]   <= '0;
      g[2]   <= {{3{1'b0}}, 1'b1, {GF{1'b0}}};
      ang[0] <= '0;
      ang[1] <= '0;
    end else begin
      case (cmd.op)
        DP_ROT_ADD:   g[rot_dst(rs)] <= sat_v((VW+20)'(rsum));
        DP_BL_WR:     g[ax]          <= sat_v((VW+20)'(bsh));
        DP_DIV_END_G: g[ax]          <= sat_v((VW+20)'(qs));
        DP_COR_END:   ang[ax[0]]     <= czero ? 16'sd0 : csat;
        default: ;
      endcase
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_LOAD: begin
        rate[0]  <= rate_x;
        rate[1]  <= rate_y;
        rate[2]  <= rate_z;
        accel[0] <= accel_x;
        accel[1] <= accel_y;
        accel[2] <= accel_z;
        ground   <= on_ground;
        horizon  <= horizon_enable;
        accepted <= 1'b0;
      end
      DP_DELTA:   d[ax] <= dclamp;
      DP_ROT_MUL: rprod <= rmul;
      DP_ASQ:     a2 <= ((ax == 2'd0) ? 36'd0 : a2) + {2'b00, asq};
      DP_SQRT_A: begin
        sx       <= SQW'({a2, 20'd0});
        sr       <= '0;
        accepted <= 1'b1;
      end
      DP_SQRT_G: begin
        sx <= SQW'(gacc);
        sr <= '0;
      end
      DP_SQRT_STEP: begin
        if (sx >= strial) begin
          sx <= sx - strial;
          sr <= (sr >> 1) + sbit;
        end else sr <= sr >> 1;
      end
      DP_DIV_A: begin
        rem  <= DVW'(amag) << (GF + 10);
        den  <= DW'(sr);
        quo  <= '0;
        dneg <= aval[16];
      end
      DP_DIV_G: begin
        rem  <= DVW'(gmag) << GF;
        den  <= DW'(sr);
        quo  <= '0;
        dneg <= gax[VW-1];
      end
      DP_DIV_STEP: begin
        if (rem >= dsh) begin
          rem <= rem - dsh;
          quo <= quo | (VW'(1) << (VW - 1 - int'(cmd.step)));
        end
      end
      DP_DIV_END_A: n    <= qs;
      DP_BL_MUL1:   bacc <= bm1;
      DP_BL_MUL2:   bacc <= bacc + bm2;
      DP_GSQ:       gacc <= ((ax == 2'd0) ? '0 : gacc) + $unsigned(gsq);
      DP_COR_INIT: begin
        czero <= (cnum == '0) && (cden == '0);
        if (cden < 0) begin
          if (cnum >= 0) begin
            cx   <= cnum;
            cy   <= -cden;
            cang <= CORDIC_HALF_PI;
          end else begin
            cx   <= -cnum;
            cy   <= cden;
            cang <= -CORDIC_HALF_PI;
          end
        end else begin
          cx   <= cden;
          cy   <= cnum;
          cang <= '0;
        end
      end
      DP_COR_STEP: begin
        if (cy >= 0) begin
          cx   <= cx + cys;
          cy   <= cy - cxs;
          cang <= cang + ATAN_Q20[cmd.step];
        end else begin
          cx   <= cx - cys;
          cy   <= cy + cxs;
          cang <= cang - ATAN_Q20[cmd.step];
        end
      end
      DP_OUT: begin
        res_grav[0] <= to_q20(g[0]);
        res_grav[1] <= to_q20(g[1]);
        res_grav[2] <= to_q20(g[2]);
        res_roll    <= ang[0];
        res_pitch   <= ang[1];
        res_acc     <= accepted;
      end
      default: ;
    endcase
  end

  assign grav_x         = res_grav[0];
  assign grav_y         = res_grav[1];
  assign grav_z         = res_grav[2];
  assign roll_angle     = res_roll;
  assign pitch_angle    = res_pitch;
  assign accel_accepted = res_acc;

endmodule

### src/imu_gravity_complementary_filter_core.sv
// The shortest path from accept to result is taken when the accel gate fails and angles are held;
//   the longest is an air step with angles, which adds square roots of max(W, 22) digits,
//   dividers of W quotient bits and the CORDIC, where W is VECTOR_WIDTH.
// One word at a time: a new word is not accepted until the last has gone to the output; the
//   iterative square root, divider and CORDIC each retire one digit or step per cycle.
// Reset (synchronous, rst high): gravity (0, 0, 1 G), angles zero, registers at defaults.
module imu_gravity_complementary_filter_core #(
  parameter int VECTOR_WIDTH = igcf_pkg::VECTOR_WIDTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [igcf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [igcf_pkg::CFG_DATA_W-1:0]  cfg_data,
  igcf_in_if.sink                          sample,
  igcf_out_if.source                       result
);
  import igcf_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencer
  igcf_ctrl #(
    .VECTOR_WIDTH(VECTOR_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample.valid),
    .in_ready (sample.ready),
    .out_valid(result.valid),
    .out_ready(result.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Arithmetic and state
  igcf_datapath #(
    .VECTOR_WIDTH(VECTOR_WIDTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .status        (status),
    .rate_x        (sample.rate_x),
    .rate_y        (sample.rate_y),
    .rate_z        (sample.rate_z),
    .accel_x       (sample.accel_x),
    .accel_y       (sample.accel_y),
    .accel_z       (sample.accel_z),
    .on_ground     (sample.on_ground),
    .horizon_enable(sample.horizon_enable),
    .grav_x        (result.grav_x),
    .grav_y        (result.grav_y),
    .grav_z        (result.grav_z),
    .roll_angle    (result.roll_angle),
    .pitch_angle   (result.pitch_angle),
    .accel_accepted(result.accel_accepted)
  );

endmodule
